[rtl/core/rlee_pkg.sv]
// Shared types, constants and helper functions of the RGB LED effect engine.
`timescale 1ns / 1ps
`default_nettype none
package rlee_pkg;

  // Effect modes as held in the mode register.
  typedef enum logic [1:0] {
    MODE_BLINK   = 2'd0,
    MODE_BREATHE = 2'd1,
    MODE_STATIC  = 2'd2,
    MODE_RAINBOW = 2'd3
  } mode_t;

  // Input action codes. Code 3 has no meaning and is ignored.
  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_BEAT    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  // Register indexes on the configuration port.
  localparam int unsigned CFG_AW      = 4;
  localparam logic [1:0]  REG_MODE    = 2'd0;
  localparam logic [1:0]  REG_COLOR   = 2'd1;
  localparam logic [1:0]  REG_BRIGHT  = 2'd2;

  // Timing and color constants.
  localparam logic [8:0]  BLINK_MS     = 9'd300;
  localparam logic [8:0]  BREATHE_MS   = 9'd12;
  localparam logic [8:0]  HUE_MS       = 9'd8;
  localparam logic [8:0]  ELAPSED_MAX  = 9'd511;
  localparam logic [10:0] HUE_STEPS    = 11'd1536;
  localparam logic [10:0] HUE_STEP     = 11'd2;
  localparam logic [6:0]  BREATHE_TOP  = 7'd127;
  localparam logic [6:0]  BEAT_DEFAULT = 7'd2;
  localparam logic [23:0] BEAT_RGB_RST = 24'hFF0055;
  localparam logic [23:0] BREATHE_RGB0 = 24'hFF69B4;
  localparam int unsigned GREEN_Q16    = 26869;
  localparam int unsigned BLUE_Q16     = 74055;

  typedef struct packed {
    mode_t       mode;
    logic [23:0] static_color;
    logic [7:0]  brightness;
  } cfg_t;

  typedef struct packed {
    logic       step;
    logic       scale_en;
    logic [1:0] scale_sel;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic emit;
  } dp_sts_t;

  // Duration of each heartbeat phase: on, off, on, long off.
  function automatic logic [8:0] beat_dur(input logic [1:0] phase);
    logic [8:0] d;
    case (phase)
      2'd3:    d = 9'd300;
      default: d = 9'd80;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] breathe_green(input logic [6:0] lvl);
    logic [21:0] p;
    p = 22'(lvl) * 22'(GREEN_Q16);
    return {2'b00, p[21:16]};
  endfunction

  function automatic logic [7:0] breathe_blue(input logic [6:0] lvl);
    logic [23:0] p;
    p = 24'(lvl) * 24'(BLUE_Q16);
    return p[23:16];
  endfunction

endpackage
`default_nettype wire

[rtl/core/rlee_in_if.sv]
// Input channel of the effect engine: action items with heartbeat settings.
`timescale 1ns / 1ps
`default_nettype none
interface rlee_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [23:0] beat_color;
  logic [6:0]  beat_pulses;

  modport source (output valid, output action, output beat_color, output beat_pulses,
                  input ready);
  modport sink   (input valid, input action, input beat_color, input beat_pulses,
                  output ready);
endinterface
`default_nettype wire

[rtl/core/rlee_out_if.sv]
// Result channel of the effect engine: scaled LED levels.
`timescale 1ns / 1ps
`default_nettype none
interface rlee_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic [7:0] blue_level;

  modport source (output valid, output red_level, output green_level, output blue_level,
                  input ready);
  modport sink   (input valid, input red_level, input green_level, input blue_level,
                  output ready);
endinterface
`default_nettype wire

[rtl/core/rlee_regs.sv]
// APB-style configuration registers: mode, static color and brightness.
`timescale 1ns / 1ps
`default_nettype none
module rlee_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rlee_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  output rlee_pkg::cfg_t                    cfg,
  output logic                              pend_set
);

  rlee_pkg::cfg_t cfg_r;
  logic           wr;
  logic [1:0]     idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // A color or brightness change shows up on the next tick in static mode.
  assign pend_set = wr && ((idx == rlee_pkg::REG_COLOR) || (idx == rlee_pkg::REG_BRIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode         <= rlee_pkg::MODE_BLINK;
      cfg_r.static_color <= 24'hFFFFFF;
      cfg_r.brightness   <= 8'hFF;
    end else if (wr) begin
      unique case (idx)
        rlee_pkg::REG_MODE:   cfg_r.mode         <= rlee_pkg::mode_t'(pwdata[1:0]);
        rlee_pkg::REG_COLOR:  cfg_r.static_color <= pwdata[23:0];
        rlee_pkg::REG_BRIGHT: cfg_r.brightness   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rlee_pkg::REG_MODE:   prdata = {30'd0, cfg_r.mode};
      rlee_pkg::REG_COLOR:  prdata = {8'd0, cfg_r.static_color};
      rlee_pkg::REG_BRIGHT: prdata = {24'd0, cfg_r.brightness};
      default:              prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/rlee_dp.sv]
// Datapath: animation state, frame color selection and the shared brightness scaler.
`timescale 1ns / 1ps
`default_nettype none
module rlee_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [1:0]        action,
  input  wire logic [23:0]       beat_color,
  input  wire logic [6:0]        beat_pulses,
  input  wire rlee_pkg::cfg_t    cfg,
  input  wire logic              pend_set,
  input  wire rlee_pkg::dp_cmd_t cmd,
  output rlee_pkg::dp_sts_t      sts,
  output logic [7:0]             red_level,
  output logic [7:0]             green_level,
  output logic [7:0]             blue_level
);

  // Animation state.
  logic [8:0]  fe_r, fe_nxt;
  logic        blink_r, blink_nxt;
  logic [6:0]  lvl_r, lvl_nxt;
  logic        rising_r, rising_nxt;
  logic        pending_r, pending_nxt;
  logic [10:0] hue_r, hue_nxt;
  logic        bactive_r, bactive_nxt;
  logic [23:0] brgb_r, brgb_nxt;
  logic [6:0]  bcount_r, bcount_nxt;
  logic [7:0]  bphase_r, bphase_nxt;
  logic [8:0]  belapsed_r, belapsed_nxt;

  // Frame color before scaling, scaled channels and the output register.
  logic [23:0] raw_r, raw_nxt;
  logic [7:0]  red_s_r, green_s_r, blue_s_r;
  logic [7:0]  red_out_r, green_out_r, blue_out_r;

  logic        emit;
  logic        restart;
  logic [8:0]  fe_inc;
  logic [8:0]  be_inc;
  logic [10:0] hue_sum;
  logic [10:0] h;
  logic [7:0]  hl;
  logic [7:0]  bright;
  logic [6:0]  lv;

  logic [7:0]  chan;
  logic [15:0] prod;
  logic [15:0] psum;
  logic [7:0]  quot;

  assign bright = cfg.brightness;
  assign fe_inc = (fe_r == rlee_pkg::ELAPSED_MAX) ? fe_r : fe_r + 9'd1;
  assign be_inc = (belapsed_r == rlee_pkg::ELAPSED_MAX) ? belapsed_r : belapsed_r + 9'd1;
  assign hue_sum = hue_r + rlee_pkg::HUE_STEP;

  always_comb begin
    fe_nxt       = fe_r;
    blink_nxt    = blink_r;
    lvl_nxt      = lvl_r;
    rising_nxt   = rising_r;
    pending_nxt  = pending_r;
    hue_nxt      = hue_r;
    bactive_nxt  = bactive_r;
    brgb_nxt     = brgb_r;
    bcount_nxt   = bcount_r;
    bphase_nxt   = bphase_r;
    belapsed_nxt = belapsed_r;
    raw_nxt      = raw_r;
    emit         = 1'b0;
    restart      = 1'b0;
    h            = 11'd0;
    hl           = 8'd0;
    lv           = 7'd0;

    if (cmd.step) begin
      case (action)
        rlee_pkg::ACT_TICK: begin
          if (bactive_r) begin
            if (bphase_r < {bcount_r, 1'b0}) begin
              belapsed_nxt = be_inc;
              if (be_inc >= rlee_pkg::beat_dur(bphase_r[1:0])) begin
                emit         = 1'b1;
                raw_nxt      = bphase_r[0] ? 24'd0 : brgb_r;
                bphase_nxt   = bphase_r + 8'd1;
                belapsed_nxt = 9'd0;
              end
            end else begin
              // All pulses done: the mode comes back as after a restart.
              bphase_nxt = 8'd0;
              restart    = 1'b1;
            end
          end else begin
            fe_nxt = fe_inc;
            unique case (cfg.mode)
              rlee_pkg::MODE_BLINK: begin
                if (fe_inc > rlee_pkg::BLINK_MS) begin
                  fe_nxt    = 9'd0;
                  blink_nxt = !blink_r;
                  emit      = 1'b1;
                  raw_nxt   = !blink_r ? {bright, bright, bright} : 24'd0;
                end
              end
              rlee_pkg::MODE_BREATHE: begin
                if (fe_inc > rlee_pkg::BREATHE_MS) begin
                  fe_nxt  = 9'd0;
                  lv      = rising_r ? lvl_r + 7'd1 : lvl_r - 7'd1;
                  lvl_nxt = lv;
                  if ((lv == 7'd0) || (lv == rlee_pkg::BREATHE_TOP)) begin
                    rising_nxt = !rising_r;
                  end
                  emit    = 1'b1;
                  raw_nxt = {lv, 1'b0, rlee_pkg::breathe_green(lv),
                             rlee_pkg::breathe_blue(lv)};
                end
              end
              rlee_pkg::MODE_STATIC: begin
                if (pending_r) begin
                  pending_nxt = 1'b0;
                  emit        = 1'b1;
                  raw_nxt     = cfg.static_color;
                end
              end
              rlee_pkg::MODE_RAINBOW: begin
                if (fe_inc > rlee_pkg::HUE_MS) begin
                  fe_nxt  = 9'd0;
                  h       = (hue_sum >= rlee_pkg::HUE_STEPS) ?
                            hue_sum - rlee_pkg::HUE_STEPS : hue_sum;
                  hue_nxt = h;
                  hl      = h[7:0];
                  emit    = 1'b1;
                  // Six sectors of 256 steps; falling ramps are the complement.
                  case (h[10:8])
                    3'd0:    raw_nxt = {bright, hl, 8'd0};
                    3'd1:    raw_nxt = {~hl, bright, 8'd0};
                    3'd2:    raw_nxt = {8'd0, bright, hl};
                    3'd3:    raw_nxt = {8'd0, ~hl, bright};
                    3'd4:    raw_nxt = {hl, 8'd0, bright};
                    default: raw_nxt = {bright, 8'd0, ~hl};
                  endcase
                end
              end
              default: ;
            endcase
          end
        end
        rlee_pkg::ACT_BEAT: begin
          bactive_nxt  = 1'b1;
          brgb_nxt     = beat_color;
          bcount_nxt   = (beat_pulses != 7'd0) ? beat_pulses : rlee_pkg::BEAT_DEFAULT;
          bphase_nxt   = 8'd0;
          belapsed_nxt = 9'd0;
        end
        rlee_pkg::ACT_RESTART: restart = 1'b1;
        default: ;
      endcase

      if (restart) begin
        fe_nxt      = 9'd0;
        blink_nxt   = 1'b0;
        lvl_nxt     = 7'd0;
        rising_nxt  = 1'b1;
        pending_nxt = 1'b1;
        bactive_nxt = 1'b0;
        emit        = 1'b1;
        unique case (cfg.mode)
          rlee_pkg::MODE_BLINK:   raw_nxt = {bright, bright, bright};
          rlee_pkg::MODE_BREATHE: raw_nxt = rlee_pkg::BREATHE_RGB0;
          rlee_pkg::MODE_STATIC:  raw_nxt = cfg.static_color;
          default:                raw_nxt = {bright, 16'd0};
        endcase
      end
    end

    if (pend_set) begin
      pending_nxt = 1'b1;
    end
  end

  assign sts.emit = emit;

  // Shared scaler: floor(v * b / 255) is exact as (p + (p >> 8) + 1) >> 8 here.
  always_comb begin
    case (cmd.scale_sel)
      2'd0:    chan = raw_r[23:16];
      2'd1:    chan = raw_r[15:8];
      default: chan = raw_r[7:0];
    endcase
  end

  assign prod = 16'(chan) * 16'(bright);
  assign psum = prod + {8'd0, prod[15:8]} + 16'd1;
  assign quot = psum[15:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_r       <= 9'd0;
      blink_r    <= 1'b0;
      lvl_r      <= 7'd0;
      rising_r   <= 1'b1;
      pending_r  <= 1'b1;
      hue_r      <= 11'd0;
      bactive_r  <= 1'b0;
      brgb_r     <= rlee_pkg::BEAT_RGB_RST;
      bcount_r   <= rlee_pkg::BEAT_DEFAULT;
      bphase_r   <= 8'd0;
      belapsed_r <= 9'd0;
    end else begin
      fe_r       <= fe_nxt;
      blink_r    <= blink_nxt;
      lvl_r      <= lvl_nxt;
      rising_r   <= rising_nxt;
      pending_r  <= pending_nxt;
      hue_r      <= hue_nxt;
      bactive_r  <= bactive_nxt;
      brgb_r     <= brgb_nxt;
      bcount_r   <= bcount_nxt;
      bphase_r   <= bphase_nxt;
      belapsed_r <= belapsed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raw_r <= raw_nxt;
    if (cmd.scale_en) begin
      case (cmd.scale_sel)
        2'd0:    red_s_r   <= quot;
        2'd1:    green_s_r <= quot;
        default: blue_s_r  <= quot;
      endcase
    end
    if (cmd.out_load) begin
      red_out_r   <= red_s_r;
      green_out_r <= green_s_r;
      blue_out_r  <= blue_s_r;
    end
  end

  assign red_level   = red_out_r;
  assign green_level = green_out_r;
  assign blue_level  = blue_out_r;

endmodule
`default_nettype wire

[rtl/core/rlee_ctrl.sv]
// Controller: takes one item, steps the scaler over three channels, fills the output register.
`timescale 1ns / 1ps
`default_nettype none
module rlee_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire rlee_pkg::dp_sts_t sts,
  output rlee_pkg::dp_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCALE,
    S_HOLD
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign cmd.step      = in_valid && (state_r == S_IDLE);
  assign cmd.scale_en  = (state_r == S_SCALE);
  assign cmd.scale_sel = cnt_r;
  // The finished result moves out once the previous one has been taken.
  assign cmd.out_load  = (state_r == S_HOLD) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (cmd.step && sts.emit) begin
          state_nxt = S_SCALE;
          cnt_nxt   = 2'd0;
        end
      end
      S_SCALE: begin
        if (cnt_r == 2'd2) begin
          state_nxt = S_HOLD;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      S_HOLD: begin
        if (cmd.out_load) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCALE) |-> (cnt_r != 2'd3))
    else $error("scaler channel count out of range");

  a_valid_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_HOLD))
    else $error("result raised without a finished scaling pass");

  a_step_next: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> ((state_r == S_IDLE) || ((state_r == S_SCALE) && (cnt_r == 2'd0))))
    else $error("accepted item did not start at the first channel");

endmodule
`default_nettype wire

[rtl/core/rgb_led_effect_engine_core.sv]
// Top level of the RGB LED effect engine: registers, controller and datapath.
//
//   channel   direction  transaction
//   in_ch     in         action, beat_color, beat_pulses
//   out_ch    out        red_level, green_level, blue_level
//   APB       in/out     effect_mode @0x0, static_color @0x4, brightness @0x8
//
// An item that gives no result is done once it is accepted; one that gives a result goes through
// the accept step, three passes through the single shared 8x8 brightness multiplier
// (red, green, blue), and a load into the output register once that register is free.
// A new item is accepted while a finished result waits in the output register;
// the next result waits in the scaler until that register is taken.
// rst_n is synchronous and active low; no clearing pass follows it.
`timescale 1ns / 1ps
`default_nettype none
module rgb_led_effect_engine_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  rlee_in_if.sink                           in_ch,
  rlee_out_if.source                        out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rlee_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);

  rlee_pkg::cfg_t    cfg;
  logic              pend_set;
  rlee_pkg::dp_cmd_t cmd;
  rlee_pkg::dp_sts_t sts;

  rlee_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .pend_set (pend_set)
  );

  rlee_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rlee_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .action      (in_ch.action),
    .beat_color  (in_ch.beat_color),
    .beat_pulses (in_ch.beat_pulses),
    .cfg         (cfg),
    .pend_set    (pend_set),
    .cmd         (cmd),
    .sts         (sts),
    .red_level   (out_ch.red_level),
    .green_level (out_ch.green_level),
    .blue_level  (out_ch.blue_level)
  );

endmodule
`default_nettype wire

[bench/rgb_led_effect_engine_core_test.sv]
// Self-checking testbench for the RGB LED effect engine core.
`timescale 1ns / 1ps
module rgb_led_effect_engine_core_test;

  localparam logic [1:0]  ACT_UNUSED    = 2'd3;
  localparam logic [8:0]  BLINK_HOLD    = 9'd300;
  localparam logic [8:0]  BREATHE_HOLD  = 9'd12;
  localparam logic [8:0]  HUE_HOLD      = 9'd8;
  localparam logic [8:0]  COUNT_CAP     = 9'd511;
  localparam logic [8:0]  BEAT_SHORT    = 9'd80;
  localparam logic [8:0]  BEAT_LONG     = 9'd300;
  localparam logic [10:0] HUE_WRAP      = 11'd1536;
  localparam logic [10:0] HUE_ADVANCE   = 11'd2;
  localparam logic [6:0]  LEVEL_TOP     = 7'd127;
  localparam logic [23:0] PINK_RGB      = 24'hFF69B4;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS  = 140;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } led_frame_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [rlee_pkg::CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  rlee_in_if  in_bus ();
  rlee_out_if led_bus ();

  rgb_led_effect_engine_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (led_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Shadow of the block's registers and animation state.
  rlee_pkg::mode_t mode_q;
  logic [23:0] color_q;
  logic [7:0]  bright_q;
  logic [8:0]  frame_ms;
  logic        blink_lit;
  logic [6:0]  breath_lvl;
  logic        breath_up;
  logic        color_due;
  logic [10:0] hue;
  logic        beat_on;
  logic [23:0] beat_rgb_q;
  logic [6:0]  beat_cnt;
  logic [7:0]  beat_ph;
  logic [8:0]  beat_ms;

  led_frame_t  frames_due[$];
  led_frame_t  seen_frame;
  led_frame_t  next_frame;
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;

  function automatic void reset_model();
    mode_q     = rlee_pkg::MODE_BLINK;
    color_q    = 24'hFFFFFF;
    bright_q   = 8'd255;
    frame_ms   = '0;
    blink_lit  = 1'b0;
    breath_lvl = '0;
    breath_up  = 1'b1;
    color_due  = 1'b1;
    hue        = '0;
    beat_on    = 1'b0;
    beat_rgb_q = 24'hFF0055;
    beat_cnt   = 7'd2;
    beat_ph    = '0;
    beat_ms    = '0;
  endfunction

  function automatic logic [7:0] dim(input logic [7:0] v);
    logic [15:0] p;
    p = v * bright_q;
    return 8'(p / 16'd255);
  endfunction

  function automatic led_frame_t shade(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
    return {dim(r), dim(g), dim(b)};
  endfunction

  function automatic led_frame_t shade_rgb(input logic [23:0] rgb);
    return shade(rgb[23:16], rgb[15:8], rgb[7:0]);
  endfunction

  function automatic led_frame_t restart_frame();
    frame_ms   = '0;
    blink_lit  = 1'b0;
    breath_lvl = '0;
    breath_up  = 1'b1;
    color_due  = 1'b1;
    beat_on    = 1'b0;
    case (mode_q)
      rlee_pkg::MODE_BLINK:   return shade(bright_q, bright_q, bright_q);
      rlee_pkg::MODE_BREATHE: return shade_rgb(PINK_RGB);
      rlee_pkg::MODE_STATIC:  return shade_rgb(color_q);
      default:                return shade(bright_q, 8'd0, 8'd0);
    endcase
  endfunction

  function automatic bit beat_frame(output led_frame_t f);
    logic [8:0] total;
    logic [8:0] dur;
    total = {1'b0, beat_cnt, 1'b0};
    if ({1'b0, beat_ph} < total) begin
      if (beat_ms != COUNT_CAP) beat_ms = beat_ms + 9'd1;
      dur = (beat_ph[1:0] == 2'd3) ? BEAT_LONG : BEAT_SHORT;
      if (beat_ms >= dur) begin
        f = beat_ph[0] ? shade(8'd0, 8'd0, 8'd0) : shade_rgb(beat_rgb_q);
        beat_ph = beat_ph + 8'd1;
        beat_ms = '0;
        return 1'b1;
      end
      return 1'b0;
    end
    // Last phase is over: the heartbeat hands the LED back to the mode.
    beat_ph = '0;
    f = restart_frame();
    return 1'b1;
  endfunction

  function automatic bit mode_frame(output led_frame_t f);
    logic [10:0] r;
    logic [10:0] g;
    logic [10:0] b;
    logic [31:0] gq;
    logic [31:0] bq;
    if (frame_ms != COUNT_CAP) frame_ms = frame_ms + 9'd1;
    case (mode_q)
      rlee_pkg::MODE_BLINK: begin
        if (frame_ms <= BLINK_HOLD) return 1'b0;
        frame_ms = '0;
        blink_lit = !blink_lit;
        f = blink_lit ? shade(bright_q, bright_q, bright_q) : shade(8'd0, 8'd0, 8'd0);
        return 1'b1;
      end
      rlee_pkg::MODE_BREATHE: begin
        if (frame_ms <= BREATHE_HOLD) return 1'b0;
        frame_ms = '0;
        breath_lvl = breath_up ? breath_lvl + 7'd1 : breath_lvl - 7'd1;
        if (breath_lvl == 7'd0 || breath_lvl == LEVEL_TOP) breath_up = !breath_up;
        gq = 32'(breath_lvl) * 32'd26869;
        bq = 32'(breath_lvl) * 32'd74055;
        f = shade({breath_lvl, 1'b0}, gq[23:16], bq[23:16]);
        return 1'b1;
      end
      rlee_pkg::MODE_STATIC: begin
        if (!color_due) return 1'b0;
        color_due = 1'b0;
        f = shade_rgb(color_q);
        return 1'b1;
      end
      default: begin
        if (frame_ms <= HUE_HOLD) return 1'b0;
        frame_ms = '0;
        hue = (hue + HUE_ADVANCE) % HUE_WRAP;
        if (hue < 11'd256) begin
          r = 11'(bright_q); g = hue; b = '0;
        end else if (hue < 11'd512) begin
          r = 11'd511 - hue; g = 11'(bright_q); b = '0;
        end else if (hue < 11'd768) begin
          r = '0; g = 11'(bright_q); b = hue - 11'd512;
        end else if (hue < 11'd1024) begin
          r = '0; g = 11'd1023 - hue; b = 11'(bright_q);
        end else if (hue < 11'd1280) begin
          r = hue - 11'd1024; g = '0; b = 11'(bright_q);
        end else begin
          r = 11'(bright_q); g = '0; b = 11'd1535 - hue;
        end
        f = shade(r[7:0], g[7:0], b[7:0]);
        return 1'b1;
      end
    endcase
  endfunction

  function automatic bit predict_frame(input logic [1:0] act, input logic [23:0] col,
                                       input logic [6:0] pul, output led_frame_t f);
    case (act)
      rlee_pkg::ACT_TICK: return beat_on ? beat_frame(f) : mode_frame(f);
      rlee_pkg::ACT_BEAT: begin
        beat_on    = 1'b1;
        beat_rgb_q = col;
        beat_cnt   = (pul != 7'd0) ? pul : 7'd2;
        beat_ph    = '0;
        beat_ms    = '0;
        return 1'b0;
      end
      rlee_pkg::ACT_RESTART: begin
        f = restart_frame();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void check_level(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Both channels are sampled at the clock edge, before the block updates them.
  always @(posedge clk) begin
    if (rst_n && led_bus.valid && led_bus.ready) begin
      if (frames_due.size() == 0) begin
        $error("unexpected result transaction: red %0d green %0d blue %0d",
               led_bus.red_level, led_bus.green_level, led_bus.blue_level);
        mismatches++;
      end else begin
        seen_frame = frames_due.pop_front();
        check_level("red_level", seen_frame.red, led_bus.red_level);
        check_level("green_level", seen_frame.green, led_bus.green_level);
        check_level("blue_level", seen_frame.blue, led_bus.blue_level);
      end
    end
    if (rst_n && in_bus.valid && in_bus.ready) begin
      if (predict_frame(in_bus.action, in_bus.beat_color, in_bus.beat_pulses, next_frame))
        frames_due.push_back(next_frame);
    end
  end

  // The receiver either takes everything or follows a periodic stall pattern.
  initial begin
    int unsigned hold;
    int unsigned period;
    int unsigned low_len;
    int unsigned phase;
    hold = 0;
    period = 1;
    low_len = 0;
    phase = 0;
    led_bus.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        hold = $urandom_range(20, 300);
        period = $urandom_range(2, 32);
        low_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, period - 1);
        phase = 0;
      end
      hold--;
      led_bus.ready <= (phase >= low_len);
      phase = (phase + 1 == period) ? 0 : phase + 1;
    end
  end

  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic send_item(input logic [1:0] act, input logic [23:0] col,
                           input logic [6:0] pul);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 4);
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_bus.valid       <= 1'b1;
    in_bus.action      <= act;
    in_bus.beat_color  <= col;
    in_bus.beat_pulses <= pul;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic run_ticks(input int unsigned n);
    repeat (n) send_item(rlee_pkg::ACT_TICK, 24'($urandom), 7'($urandom));
  endtask

  // Lets the block drain completely, including an item that gives no result.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      rlee_pkg::REG_MODE:  mode_q = rlee_pkg::mode_t'(val[1:0]);
      rlee_pkg::REG_COLOR: begin
        color_q = val[23:0];
        color_due = 1'b1;
      end
      rlee_pkg::REG_BRIGHT: begin
        bright_q = val[7:0];
        color_due = 1'b1;
      end
      default: ;
    endcase
  endtask

  function automatic logic [31:0] corner_value(input logic [31:0] mask);
    case ($urandom_range(0, 3))
      0:       return 32'd0;
      1:       return mask;
      default: return $urandom & mask;
    endcase
  endfunction

  task automatic test_blink();
    send_item(ACT_UNUSED, 24'hFFFFFF, 7'h7F);
    wait_idle();
    cfg_write(rlee_pkg::REG_BRIGHT, 32'd128);
    send_item(rlee_pkg::ACT_RESTART, 24'h0, 7'h0);
    run_ticks(1);
    wait_idle();
    cfg_write(rlee_pkg::REG_BRIGHT, 32'd0);
    send_item(rlee_pkg::ACT_RESTART, 24'h0, 7'h0);
    run_ticks(1);
    wait_idle();
    cfg_write(rlee_pkg::REG_BRIGHT, 32'd255);
    send_item(rlee_pkg::ACT_RESTART, 24'h0, 7'h0);
    // The LED turns on at the first tick past the hold time.
    run_ticks(302);
    wait_idle();
    // The frame counter keeps running in static mode and saturates there.
    cfg_write(rlee_pkg::REG_MODE, 32'(rlee_pkg::MODE_STATIC));
    run_ticks(515);
    wait_idle();
    // Blink then turns the LED off on its first tick.
    cfg_write(rlee_pkg::REG_MODE, 32'(rlee_pkg::MODE_BLINK));
    run_ticks(2);
    wait_idle();
  endtask

  task automatic test_breathing();
    cfg_write(rlee_pkg::REG_MODE, 32'(rlee_pkg::MODE_BREATHE));
    cfg_write(rlee_pkg::REG_BRIGHT, 32'd255);
    send_item(rlee_pkg::ACT_RESTART, 24'h0, 7'h0);
    run_ticks(13 * 4);
    wait_idle();
    cfg_write(rlee_pkg::REG_BRIGHT, 32'd77);
    send_item(rlee_pkg::ACT_RESTART, 24'h0, 7'h0);
    run_ticks(13 * 2);
    wait_idle();
  endtask

  task automatic test_static_color();
    cfg_write(rlee_pkg::REG_MODE, 32'(rlee_pkg::MODE_STATIC));
    cfg_write(rlee_pkg::REG_COLOR, 32'h123456);
    cfg_write(rlee_pkg::REG_BRIGHT, 32'd255);
    run_ticks(2);
    // A restart in static mode leaves the color pending for the next tick.
    send_item(rlee_pkg::ACT_RESTART, 24'h0, 7'h0);
    run_ticks(2);
    wait_idle();
    cfg_write(rlee_pkg::REG_COLOR, 32'hFFFFFF);
    cfg_write(rlee_pkg::REG_BRIGHT, 32'd0);
    run_ticks(2);
    wait_idle();
    cfg_write(rlee_pkg::REG_COLOR, 32'h000000);
    cfg_write(rlee_pkg::REG_BRIGHT, 32'd255);
    run_ticks(2);
    wait_idle();
    cfg_write(rlee_pkg::REG_COLOR, 32'hFFFFFF);
    run_ticks(1);
    wait_idle();
  endtask

  task automatic test_rainbow();
    cfg_write(rlee_pkg::REG_MODE, 32'(rlee_pkg::MODE_RAINBOW));
    cfg_write(rlee_pkg::REG_BRIGHT, 32'd200);
    send_item(rlee_pkg::ACT_RESTART, 24'h0, 7'h0);
    run_ticks(9 * 12);
    // The hue position survives a restart.
    send_item(rlee_pkg::ACT_RESTART, 24'h0, 7'h0);
    run_ticks(9 * 3);
    wait_idle();
    cfg_write(rlee_pkg::REG_BRIGHT, 32'd255);
    run_ticks(9 * 2);
    wait_idle();
  endtask

  task automatic test_heartbeat();
    cfg_write(rlee_pkg::REG_MODE, 32'(rlee_pkg::MODE_BREATHE));
    // Zero pulses means two: on, off, on and the long off.
    send_item(rlee_pkg::ACT_BEAT, 24'hFFFFFF, 7'd0);
    run_ticks(200);
    wait_idle();
    // A mode change during the heartbeat takes effect when it ends.
    cfg_write(rlee_pkg::REG_MODE, 32'(rlee_pkg::MODE_RAINBOW));
    run_ticks(345);
    wait_idle();
    // A restart in the middle of a heartbeat cancels it.
    send_item(rlee_pkg::ACT_BEAT, 24'($urandom), 7'd127);
    run_ticks(82);
    send_item(rlee_pkg::ACT_RESTART, 24'h0, 7'h0);
    run_ticks(3);
    // A new heartbeat replaces one that is still running.
    send_item(rlee_pkg::ACT_BEAT, 24'h00FF00, 7'd2);
    run_ticks(20);
    send_item(rlee_pkg::ACT_BEAT, 24'h0000FF, 7'd1);
    run_ticks(85);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int unsigned budget;
    int unsigned span;
    int unsigned pick;
    int unsigned beat_pct;
    int unsigned restart_pct;
    logic [1:0]  act;
    logic [6:0]  pul;
    budget = RANDOM_ITEMS;
    while (budget > 0) begin
      wait_idle();
      if ($urandom_range(0, 1) != 0) cfg_write(rlee_pkg::REG_MODE, 32'($urandom_range(0, 3)));
      if ($urandom_range(0, 2) == 0) cfg_write(rlee_pkg::REG_COLOR, corner_value(32'hFFFFFF));
      if ($urandom_range(0, 2) == 0) cfg_write(rlee_pkg::REG_BRIGHT, corner_value(32'hFF));
      if ($urandom_range(0, 3) == 0) begin
        // Heartbeat run: a short beat followed by a stretch of ticks.
        send_item(rlee_pkg::ACT_BEAT, 24'($urandom), 7'($urandom_range(0, 2)));
        budget--;
        span = $urandom_range(40, 120);
        beat_pct = 0;
        restart_pct = 1;
      end else begin
        if ($urandom_range(0, 9) < 7) begin
          send_item(rlee_pkg::ACT_RESTART, 24'($urandom), 7'($urandom));
          budget--;
        end
        span = $urandom_range(10, 60);
        beat_pct = 3;
        restart_pct = 4;
      end
      while (span > 0 && budget > 0) begin
        pick = $urandom_range(0, 99);
        if (pick < beat_pct) act = rlee_pkg::ACT_BEAT;
        else if (pick < beat_pct + restart_pct) act = rlee_pkg::ACT_RESTART;
        else if (pick < beat_pct + restart_pct + 2) act = ACT_UNUSED;
        else act = rlee_pkg::ACT_TICK;
        pul = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 2));
        send_item(act, 24'($urandom), pul);
        if (act != ACT_UNUSED) begin
          budget--;
          span--;
        end
      end
    end
    wait_idle();
  endtask

  initial begin
    rst_n              <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_bus.valid       <= 1'b0;
    in_bus.action      <= rlee_pkg::ACT_TICK;
    in_bus.beat_color  <= '0;
    in_bus.beat_pulses <= '0;
    reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_blink();
    test_breathing();
    test_static_color();
    test_rainbow();
    test_heartbeat();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
